// ===== hw/rtl/line_start_index_locator_assert.svh =====
// Assertion macros for the line start index locator.
// Each macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef LINE_START_INDEX_LOCATOR_ASSERT_SVH
`define LINE_START_INDEX_LOCATOR_ASSERT_SVH

// Same-cycle implication.
`define LSIL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsil_pkg.sv =====
// ----------------------------------------------------------------------------
// lsil_pkg
// Shared types and constants of the line start index locator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsil_pkg;

  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned LINE_W         = 13;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned MAX_LINES_DEF  = 4096;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  localparam logic [OP_W-1:0]   OP_START  = 2'd0;
  localparam logic [OP_W-1:0]   OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0]   OP_LOCATE = 2'd2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

  typedef struct packed {
    logic               present;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic [LINE_W-1:0]  line;
    logic [FIELD_W-1:0] column;
  } result_t;

endpackage

// ===== hw/rtl/lsil_line_table.sv =====
// ----------------------------------------------------------------------------
// lsil_line_table
// Line start offset memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsil_line_table #(
  parameter int unsigned MAX_LINES   = lsil_pkg::MAX_LINES_DEF,
  parameter int unsigned OFFSET_BITS = lsil_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IW         = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IW-1:0]          wr_addr_i,
  input  logic [OFFSET_BITS-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [IW-1:0]          rd_addr_i,
  output logic [OFFSET_BITS-1:0] rd_data_o
);
  import lsil_pkg::*;

  logic [OFFSET_BITS-1:0] mem_q [MAX_LINES];
  logic [OFFSET_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/lsil_locate.sv =====
// ----------------------------------------------------------------------------
// lsil_locate
// Locate sequencer: clamp, binary search over the line table, column math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsil_locate #(
  parameter int unsigned MAX_LINES   = lsil_pkg::MAX_LINES_DEF,
  parameter int unsigned OFFSET_BITS = lsil_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IW         = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1,
  localparam int unsigned CW         = $clog2(MAX_LINES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           loaded_i,
  input  logic [lsil_pkg::FIELD_W-1:0]   off_i,
  input  logic [lsil_pkg::FIELD_W-1:0]   len_i,
  input  logic [OFFSET_BITS-1:0]         size_i,
  input  logic [CW-1:0]                  count_i,
  output logic                           rd_en_o,
  output logic [IW-1:0]                  rd_addr_o,
  input  logic [OFFSET_BITS-1:0]         rd_data_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output lsil_pkg::result_t              res_o
);
  import lsil_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLAMP  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   inflight_q, inflight_d;
  logic                   valid_q, valid_d;
  logic [OFFSET_BITS-1:0] safe_q, safe_d;
  logic [FIELD_W-1:0]     len_q, len_d;
  logic [CW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [OFFSET_BITS-1:0] base_q, base_d;
  result_t                res_q, res_d;

  logic [OFFSET_BITS-1:0] rem;
  logic                   le;
  logic [CW-1:0]          lo_n, hi_n, span_n;
  logic [FIELD_W:0]       col_ext;
  logic [CW+LINE_W-1:0]   lo_ext;

  assign rem     = size_i - safe_q;
  assign le      = rd_data_i <= safe_q;
  assign span_n  = hi_n - lo_n;
  assign col_ext = {1'b0, FIELD_W'(safe_q)} - (FIELD_W + 1)'(base_q) + (FIELD_W + 1)'(1);
  assign lo_ext  = (CW + LINE_W)'(lo_q);

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (inflight_q) begin
      if (le) begin
        lo_n = mid_q + CW'(1);
      end else begin
        hi_n = mid_q;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    inflight_d = inflight_q;
    valid_d    = 1'b0;
    safe_d     = safe_q;
    len_d      = len_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    base_d     = base_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = mid_q[IW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (loaded_i) begin
            safe_d     = (off_i < FIELD_W'(size_i)) ? off_i[OFFSET_BITS-1:0] : size_i;
            len_d      = len_i;
            lo_d       = '0;
            hi_d       = count_i;
            inflight_d = 1'b0;
            state_d    = ST_CLAMP;
          end else begin
            res_d.present = 1'b0;
            res_d.offset  = off_i;
            res_d.length  = len_i;
            res_d.line    = '0;
            res_d.column  = '0;
            valid_d       = 1'b1;
          end
        end
      end
      ST_CLAMP: begin
        if (len_q > FIELD_W'(rem)) begin
          len_d = FIELD_W'(rem);
        end
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (inflight_q && le) begin
          base_d = rd_data_i;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d      = lo_n + (span_n >> 1);
          rd_en_o    = 1'b1;
          rd_addr_o  = mid_d[IW-1:0];
          inflight_d = 1'b1;
        end else begin
          inflight_d = 1'b0;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_d.present = 1'b1;
        res_d.offset  = FIELD_W'(safe_q);
        res_d.length  = len_q;
        res_d.line    = lo_ext[LINE_W-1:0];
        res_d.column  = col_ext[FIELD_W] ? '1 : col_ext[FIELD_W-1:0];
        valid_d       = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      inflight_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      inflight_q <= inflight_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    safe_q <= safe_d;
    len_q  <= len_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    base_q <= base_d;
    res_q  <= res_d;
  end

  assign busy_o      = state_q != ST_IDLE;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/line_start_index_locator.sv =====
// ----------------------------------------------------------------------------
// line_start_index_locator
// Records line start offsets of an appended text and locates byte offsets
// as 1-based line and column numbers.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  command   start_i, busy_o             operation_i, text_byte_i,
//                                        query_offset_i, query_length_i
//  result    result_valid_o (strobe)     text_present_o, clamped_offset_o,
//                                        clamped_length_o, line_number_o,
//                                        column_number_o
//
//  Start and append commands keep busy_o low. A locate on a loaded text holds
//  busy_o through one clamp step, one line table read per search step plus a
//  last compare, and one finish step. Its result strobes in the first cycle
//  with busy_o low. A locate before any start strobes the next cycle.
//  Reset clears the text state; the line table needs no clearing pass.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_start_index_locator #(
  parameter int unsigned MAX_LINES   = lsil_pkg::MAX_LINES_DEF,
  parameter int unsigned OFFSET_BITS = lsil_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [lsil_pkg::OP_W-1:0]     operation_i,
  input  logic [lsil_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic [lsil_pkg::FIELD_W-1:0]  query_offset_i,
  input  logic [lsil_pkg::FIELD_W-1:0]  query_length_i,
  output logic                          result_valid_o,
  output logic                          text_present_o,
  output logic [lsil_pkg::FIELD_W-1:0]  clamped_offset_o,
  output logic [lsil_pkg::FIELD_W-1:0]  clamped_length_o,
  output logic [lsil_pkg::LINE_W-1:0]   line_number_o,
  output logic [lsil_pkg::FIELD_W-1:0]  column_number_o
);
  import lsil_pkg::*;

  localparam int unsigned IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CW = $clog2(MAX_LINES + 1);

  logic [CW-1:0]          count_q, count_d;
  logic [OFFSET_BITS-1:0] size_q, size_d;
  logic                   nl_pend_q, nl_pend_d;
  logic                   loaded_q, loaded_d;

  logic                   xfer;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [OFFSET_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [OFFSET_BITS-1:0] rd_data;
  logic                   loc_busy;
  logic                   res_valid;
  result_t                res;

  assign xfer = start_i && !busy_o;

  always_comb begin
    count_d   = count_q;
    size_d    = size_q;
    nl_pend_d = nl_pend_q;
    loaded_d  = loaded_q;
    wr_en     = 1'b0;
    wr_addr   = count_q[IW-1:0];
    wr_data   = size_q;
    if (xfer) begin
      unique case (operation_i)
        OP_START: begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = '0;
          count_d   = CW'(1);
          size_d    = '0;
          nl_pend_d = 1'b0;
          loaded_d  = 1'b1;
        end
        OP_APPEND: begin
          if (loaded_q) begin
            if (nl_pend_q && (count_q < CW'(MAX_LINES))) begin
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
            end
            nl_pend_d = text_byte_i == NEWLINE_BYTE;
            if (size_q != '1) begin
              size_d = size_q + OFFSET_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      size_q    <= '0;
      nl_pend_q <= 1'b0;
      loaded_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      size_q    <= size_d;
      nl_pend_q <= nl_pend_d;
      loaded_q  <= loaded_d;
    end
  end

  lsil_line_table #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lsil_locate #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (xfer && (operation_i == OP_LOCATE)),
    .loaded_i    (loaded_q),
    .off_i       (query_offset_i),
    .len_i       (query_length_i),
    .size_i      (size_q),
    .count_i     (count_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (loc_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign busy_o           = loc_busy;
  assign result_valid_o   = res_valid;
  assign text_present_o   = res.present;
  assign clamped_offset_o = res.offset;
  assign clamped_length_o = res.length;
  assign line_number_o    = res.line;
  assign column_number_o  = res.column;

`include "line_start_index_locator_assert.svh"

  `LSIL_ASSERT_IMPL(a_col_nonzero, result_valid_o && text_present_o, column_number_o != '0, "present result with zero column")
  `LSIL_ASSERT_NEXT(a_locate_busy, xfer && (operation_i == OP_LOCATE) && loaded_q, busy_o, "locate transfer did not raise busy")
  `LSIL_ASSERT_IMPL(a_no_strobe_busy, busy_o, !result_valid_o, "result strobe during search")
  `LSIL_ASSERT_IMPL(a_count_bound, loaded_q, (count_q != '0) && (count_q <= CW'(MAX_LINES)), "line count out of range")

endmodule
